### sv/mtet_pkg.sv
package mtet_pkg;

	// Encoder and tracker dimensions.
	localparam int COUNT_BITS      = 14;
	localparam int TURN_BITS       = 16;
	localparam int ALPHA_FRAC_BITS = 8;

	// Register widths fixed by the register map.
	localparam int STEP_BITS       = 14;
	localparam int OFFSET_BITS     = 14;
	localparam int ABS_OFFSET_BITS = 30;
	localparam int POSITION_BITS   = 40;
	localparam int CFG_DATA_BITS   = 30;
	localparam int CFG_INDEX_BITS  = 3;

	localparam int FILTER_BITS = COUNT_BITS + ALPHA_FRAC_BITS;
	localparam int ALPHA_BITS  = ALPHA_FRAC_BITS + 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_COUNT   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EMA_WEIGHT     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_STEP       = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CROSS_LIMIT    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_CW      = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_CCW     = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_ABS     = 3'd6;

	// Reset values of the registers.
	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE          = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
	localparam logic [STEP_BITS-1:0]  MAX_STEP_RESET     = STEP_BITS'(2048);
	localparam logic [STEP_BITS-1:0]  WRAP_THRESH_RESET  = STEP_BITS'(7737);

	typedef enum logic [1:0] {
		EV_NORMAL   = 2'd0,
		EV_TURN_DEC = 2'd1,
		EV_TURN_INC = 2'd2,
		EV_SPURIOUS = 2'd3
	} wrap_event_t;

	typedef struct packed {
		logic                              invert_count;
		logic [ALPHA_BITS-1:0]             ema_weight;
		logic [STEP_BITS-1:0]              max_step;
		logic [STEP_BITS-1:0]              cross_limit;
		logic [OFFSET_BITS-1:0]            offset_cw;
		logic [OFFSET_BITS-1:0]            offset_ccw;
		logic signed [ABS_OFFSET_BITS-1:0] offset_abs;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] encoder_count;
		logic                  counterclockwise;
		logic                  apply_abs_offset;
	} item_t;

	typedef struct packed {
		logic [FILTER_BITS-1:0]      filter_value;
		logic                        filter_started;
		logic [COUNT_BITS-1:0]       previous_angle;
		logic signed [TURN_BITS-1:0] turn_counter;
	} track_state_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0]           rotor_angle;
		logic signed [POSITION_BITS-1:0] position;
		logic signed [TURN_BITS-1:0]     turn_total;
		wrap_event_t                     wrap_event;
		logic                            turn_saturated;
	} result_t;

endpackage

### sv/mtet_step.sv
module mtet_step (
	input  mtet_pkg::cfg_t         cfg,
	input  mtet_pkg::track_state_t state_cur,
	input  mtet_pkg::item_t        item,
	output mtet_pkg::track_state_t state_next,
	output mtet_pkg::result_t      result
);
	import mtet_pkg::*;

	localparam int PROD_BITS = FILTER_BITS + ALPHA_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int CMP_BITS  = ((COUNT_BITS > STEP_BITS) ? COUNT_BITS : STEP_BITS) + 2;
	localparam logic [FILTER_BITS:0] HALF_LSB = (FILTER_BITS + 1)'(1) << (ALPHA_FRAC_BITS - 1);
	localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

	logic [COUNT_BITS-1:0]         sample;
	logic [ALPHA_BITS-1:0]         alpha;
	logic [ALPHA_BITS-1:0]         beta;
	logic [FILTER_BITS-1:0]        sample_fx;
	logic [FILTER_BITS-1:0]        filter_old;
	logic [PROD_BITS-1:0]          prod_new;
	logic [PROD_BITS-1:0]          prod_old;
	logic [SUM_BITS-1:0]           filter_sum;
	logic [FILTER_BITS-1:0]        filter_new;
	logic [FILTER_BITS:0]          filter_round;
	logic [COUNT_BITS-1:0]         angle;
	logic signed [COUNT_BITS:0]    delta;
	logic signed [CMP_BITS-1:0]    delta_w;
	logic signed [CMP_BITS-1:0]    max_w;
	logic signed [CMP_BITS-1:0]    wrap_w;
	logic signed [TURN_BITS-1:0]   turn_new;
	wrap_event_t                   event_code;
	logic                          sat;
	logic [OFFSET_BITS-1:0]        dir_offset;
	logic signed [POSITION_BITS-1:0] pos_base;

	always_comb begin
		sample = cfg.invert_count ? (COUNT_BITS'(0) - item.encoder_count) : item.encoder_count;
		alpha = (cfg.ema_weight > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_weight;
		beta = ALPHA_ONE - alpha;
		sample_fx = {sample, {ALPHA_FRAC_BITS{1'b0}}};
		// The first sample seeds the filter with itself.
		filter_old = state_cur.filter_started ? state_cur.filter_value : sample_fx;
		prod_new = PROD_BITS'(alpha) * PROD_BITS'(sample_fx);
		prod_old = PROD_BITS'(beta) * PROD_BITS'(filter_old);
		filter_sum = SUM_BITS'(prod_new) + SUM_BITS'(prod_old) + SUM_BITS'(HALF_LSB);
		filter_new = FILTER_BITS'(filter_sum >> ALPHA_FRAC_BITS);
		filter_round = (FILTER_BITS + 1)'(filter_new) + HALF_LSB;
		angle = filter_round[ALPHA_FRAC_BITS +: COUNT_BITS];
	end

	always_comb begin
		delta = $signed({1'b0, angle}) - $signed({1'b0, state_cur.previous_angle});
		delta_w = CMP_BITS'(delta);
		max_w = $signed(CMP_BITS'(cfg.max_step));
		wrap_w = $signed(CMP_BITS'(cfg.cross_limit));
		turn_new = state_cur.turn_counter;
		event_code = EV_NORMAL;
		sat = 1'b0;
		if (!((delta_w < max_w) && (-delta_w < max_w))) begin
			priority if (delta_w > wrap_w) begin
				event_code = EV_TURN_DEC;
				if (state_cur.turn_counter > TURN_MIN) begin
					turn_new = state_cur.turn_counter - TURN_BITS'(1);
				end else begin
					sat = 1'b1;
				end
			end else if (delta_w < -wrap_w) begin
				event_code = EV_TURN_INC;
				if (state_cur.turn_counter < TURN_MAX) begin
					turn_new = state_cur.turn_counter + TURN_BITS'(1);
				end else begin
					sat = 1'b1;
				end
			end else begin
				event_code = EV_SPURIOUS;
			end
		end
	end

	always_comb begin
		dir_offset = item.counterclockwise ? cfg.offset_ccw : cfg.offset_cw;
		pos_base = POSITION_BITS'($signed({turn_new, angle}));

		state_next.filter_value   = filter_new;
		state_next.filter_started = 1'b1;
		state_next.previous_angle = angle;
		state_next.turn_counter   = turn_new;

		result.rotor_angle    = angle - COUNT_BITS'(dir_offset);
		result.position       = item.apply_abs_offset ?
			(pos_base - POSITION_BITS'(cfg.offset_abs)) : pos_base;
		result.turn_total     = turn_new;
		result.wrap_event     = event_code;
		result.turn_saturated = sat;
	end

endmodule

### sv/multi_turn_encoder_tracker.sv
// Multi-turn encoder tracker: takes one single-turn encoder count per input beat, optionally
// inverts it, smooths it with an exponential average (weight of the new sample in Q8, the first
// sample after reset seeds the filter) and counts whole turns from jumps of the rounded angle
// across the zero point. Each input beat yields exactly one output beat carrying the
// offset-corrected single-turn angle, the signed 40-bit multi-turn position, the saturating
// turn count, a wrap event code and a saturation flag. An input beat is registered, processed
// by the filter/unwrap logic (two small multipliers, an add and the turn compares) and lands in
// the output register. One beat per cycle is sustained while out_stall is low; the filter and
// turn state close their loop within the filter/unwrap logic. A new beat is taken while a
// result waits in the output register. Registers are written through cfg_we/cfg_index/cfg_data
// and should only be changed while no beat is in flight; an unknown index is ignored.
module multi_turn_encoder_tracker (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  cfg_we,
	input  logic [mtet_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mtet_pkg::CFG_DATA_BITS-1:0]    cfg_data,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mtet_pkg::COUNT_BITS-1:0]       encoder_count,
	input  logic                                  counterclockwise,
	input  logic                                  apply_abs_offset,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mtet_pkg::COUNT_BITS-1:0]       rotor_angle_counts,
	output logic signed [mtet_pkg::POSITION_BITS-1:0] absolute_position,
	output logic signed [mtet_pkg::TURN_BITS-1:0] turn_total,
	output logic [1:0]                            wrap_event,
	output logic                                  turn_saturated
);
	import mtet_pkg::*;

	cfg_t         cfg_q;
	track_state_t state_q;
	track_state_t state_next;
	item_t        item_s1;
	logic         valid_s1;
	result_t      result_comb;
	result_t      result_s2;
	logic         valid_s2;
	logic         advance;
	logic         in_accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_count   <= 1'b0;
			cfg_q.ema_weight     <= ALPHA_ONE;
			cfg_q.max_step       <= MAX_STEP_RESET;
			cfg_q.cross_limit    <= WRAP_THRESH_RESET;
			cfg_q.offset_cw      <= '0;
			cfg_q.offset_ccw     <= '0;
			cfg_q.offset_abs     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INVERT_COUNT:   cfg_q.invert_count   <= cfg_data[0];
				REG_EMA_WEIGHT:     cfg_q.ema_weight     <= cfg_data[ALPHA_BITS-1:0];
				REG_MAX_STEP:       cfg_q.max_step       <= cfg_data[STEP_BITS-1:0];
				REG_CROSS_LIMIT:    cfg_q.cross_limit    <= cfg_data[STEP_BITS-1:0];
				REG_OFFSET_CW:      cfg_q.offset_cw      <= cfg_data[OFFSET_BITS-1:0];
				REG_OFFSET_CCW:     cfg_q.offset_ccw     <= cfg_data[OFFSET_BITS-1:0];
				REG_OFFSET_ABS:     cfg_q.offset_abs     <= $signed(cfg_data[ABS_OFFSET_BITS-1:0]);
				default: begin
				end
			endcase
		end
	end

	// The processing stage moves its beat on whenever the output register is empty or is
	// being emptied in the same cycle. The input side stalls only while a beat sits in the
	// input register and cannot move on.
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.encoder_count    <= encoder_count;
			item_s1.counterclockwise <= counterclockwise;
			item_s1.apply_abs_offset <= apply_abs_offset;
		end
	end

	mtet_step u_step (
		.cfg        (cfg_q),
		.state_cur  (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result_comb)
	);

	// Tracking state is updated exactly when a beat is handed to the output register, so the
	// state always reflects the most recent result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	assign out_valid          = valid_s2;
	assign rotor_angle_counts = result_s2.rotor_angle;
	assign absolute_position  = result_s2.position;
	assign turn_total         = result_s2.turn_total;
	assign wrap_event         = result_s2.wrap_event;
	assign turn_saturated     = result_s2.turn_saturated;

`ifndef NO_ASSERTIONS
	// A blocked turn change is only ever reported with a turn event.
	a_sat_has_turn_event: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.turn_saturated) |->
		(result_s2.wrap_event == EV_TURN_DEC || result_s2.wrap_event == EV_TURN_INC))
		else $error("turn_saturated without a turn event");

	// The shown turn count is the live tracking state.
	a_turn_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.turn_total == state_q.turn_counter))
		else $error("turn_total differs from the turn counter");

	// Any delivered result implies the filter has been seeded.
	a_filter_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> state_q.filter_started)
		else $error("result present with unseeded filter");

	// A result that was not taken is still there on the next edge.
	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> valid_s2)
		else $error("result dropped while stalled");
`endif

endmodule

### tb/sv/multi_turn_encoder_tracker_tb.sv
module multi_turn_encoder_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtet_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	// The long receiver hold-off used to back the block up into its input.
	localparam int LONG_HOLD     = 300;
	// Cycles without any accepted beat or register write before the run is declared hung.
	// The longest legitimate quiet stretch is the long hold-off above.
	localparam int QUIET_LIMIT   = 4000;
	// Each result passes the input and output registers; this leaves a comfortable margin.
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 80;
	localparam int TURN_HI       = (1 << (TURN_BITS - 1)) - 1;
	localparam int TURN_LO       = -(1 << (TURN_BITS - 1));
	localparam int ROUND_HALF    = 1 << (ALPHA_FRAC_BITS - 1);

	// Index 7 has no register behind it; writes there must be ignored.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

	localparam cfg_t RESET_SETTING = '{1'b0, ALPHA_ONE, MAX_STEP_RESET, WRAP_THRESH_RESET,
		'0, '0, '0};

	// One row of the directed table. Rows marked typed carry the result that must come
	// back; the other rows are checked against the predictor.
	typedef struct {
		logic [COUNT_BITS-1:0]           count;
		logic                            ccw;
		logic                            with_abs;
		bit                              typed;
		logic [COUNT_BITS-1:0]           angle;
		logic signed [POSITION_BITS-1:0] position;
		logic signed [TURN_BITS-1:0]     turns;
		wrap_event_t                     event_code;
	} sample_row_t;

	localparam int DIRECTED_ROWS = 17;

	// The table runs with the reset register values: step limit 2048, wrap threshold 7737,
	// no filtering and zero offsets, so the first rows can be worked out by hand.
	sample_row_t directed_rows [DIRECTED_ROWS] = '{
		// First sample after reset lands near full scale: it seeds the filter, but the jump
		// from the zero previous angle still counts as a wrap and takes one turn off.
		'{14'd16383, 1'b0, 1'b0, 1'b1, 14'd16383, -40'sd1, -16'sd1, EV_TURN_DEC},
		// Back across zero the other way.
		'{14'd0, 1'b1, 1'b0, 1'b1, 14'd0, 40'sd0, 16'sd0, EV_TURN_INC},
		'{14'd8000, 1'b0, 1'b1, 1'b1, 14'd8000, -40'sd8384, -16'sd1, EV_TURN_DEC},
		// A large jump that stays inside the wrap threshold is flagged and ignored.
		'{14'd4000, 1'b1, 1'b1, 1'b1, 14'd4000, -40'sd12384, -16'sd1, EV_SPURIOUS},
		// One count short of the step limit is still normal motion.
		'{14'd6047, 1'b0, 1'b0, 1'b1, 14'd6047, -40'sd10337, -16'sd1, EV_NORMAL},
		// Exactly the step limit, up and down, and one short of it downward.
		'{14'd8095, 1'b0, 1'b0, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'd6048, 1'b1, 1'b0, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'd4000, 1'b0, 1'b1, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		// Exactly the wrap threshold in both directions is not yet a wrap.
		'{14'd11737, 1'b1, 1'b1, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'd4000, 1'b0, 1'b0, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		// One count beyond it is.
		'{14'd11738, 1'b0, 1'b1, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'd4000, 1'b1, 1'b0, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		// No motion at all, then three jumps counted as wraps and one flagged as spurious.
		'{14'd4000, 1'b1, 1'b1, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'd16383, 1'b1, 1'b1, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'd1, 1'b0, 1'b1, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'h2AAA, 1'b0, 1'b1, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL},
		'{14'h1555, 1'b1, 1'b0, 1'b0, 14'd0, 40'sd0, 16'sd0, EV_NORMAL}
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [CFG_INDEX_BITS-1:0]       cfg_index;
	logic [CFG_DATA_BITS-1:0]        cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic [COUNT_BITS-1:0]           encoder_count;
	logic                            counterclockwise;
	logic                            apply_abs_offset;
	logic                            out_valid;
	logic                            out_stall;
	logic [COUNT_BITS-1:0]           rotor_angle_counts;
	logic signed [POSITION_BITS-1:0] absolute_position;
	logic signed [TURN_BITS-1:0]     turn_total;
	logic [1:0]                      wrap_event;
	logic                            turn_saturated;

	// Copy of the register file as the block should see it, and the tracker state that
	// the predictor carries from one sample to the next.
	cfg_t                            reg_shadow;
	logic [FILTER_BITS-1:0]          ema_acc;
	bit                              ema_seeded;
	logic [COUNT_BITS-1:0]           last_angle;
	int                              turn_count;

	// Results still owed by the block, oldest first.
	result_t                         pending_results [$];
	int                              mismatch_count = 0;
	int                              quiet_cycles = 0;

	// Both sides insert gaps only while this is set; the main sequence clears it for the
	// stretches that should run at full rate.
	bit                              gaps_on = 1'b1;
	// Set by the main sequence to ask the receiver for one long hold-off.
	bit                              hold_req = 1'b0;

	multi_turn_encoder_tracker i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.encoder_count      (encoder_count),
		.counterclockwise   (counterclockwise),
		.apply_abs_offset   (apply_abs_offset),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.rotor_angle_counts (rotor_angle_counts),
		.absolute_position  (absolute_position),
		.turn_total         (turn_total),
		.wrap_event         (wrap_event),
		.turn_saturated     (turn_saturated)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Length of one idle stretch, drawn from a short range most of the time and a long one now and then.
	function automatic int pause_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// Works out the result of one sample and advances the tracker state. The filter runs
	// in Q8 with round-half-up, the rounded angle is compared with the previous one, and
	// the turn counter moves only on jumps that reach the step limit and pass the wrap threshold.
	function automatic result_t track_sample(input item_t smp);
		logic [COUNT_BITS-1:0] reading;
		logic [COUNT_BITS-1:0] angle;
		logic [COUNT_BITS-1:0] offs;
		longint unsigned       weight;
		longint unsigned       acc;
		int                    delta;
		int                    step_lim;
		int                    wrap_lim;
		longint                pos;
		result_t               r;

		reading = smp.encoder_count;
		// Inversion is the two's complement within one turn, so zero stays zero.
		if (reg_shadow.invert_count)
			reading = -reading;

		if (!ema_seeded) begin
			ema_acc    = FILTER_BITS'(reading) << ALPHA_FRAC_BITS;
			ema_seeded = 1'b1;
		end
		// Weights above one are clamped to one.
		weight = (reg_shadow.ema_weight > ALPHA_ONE) ? ALPHA_ONE : reg_shadow.ema_weight;
		acc = (weight * (longint'(reading) << ALPHA_FRAC_BITS)
			+ (longint'(ALPHA_ONE) - weight) * ema_acc + ROUND_HALF) >> ALPHA_FRAC_BITS;
		ema_acc = FILTER_BITS'(acc);
		angle   = COUNT_BITS'((ema_acc + ROUND_HALF) >> ALPHA_FRAC_BITS);

		delta    = int'(angle) - int'(last_angle);
		step_lim = int'(reg_shadow.max_step);
		wrap_lim = int'(reg_shadow.cross_limit);
		r.wrap_event     = EV_NORMAL;
		r.turn_saturated = 1'b0;
		if (delta >= step_lim || -delta >= step_lim) begin
			if (delta > wrap_lim) begin
				r.wrap_event = EV_TURN_DEC;
				if (turn_count > TURN_LO)
					turn_count--;
				else
					r.turn_saturated = 1'b1;
			end else if (delta < -wrap_lim) begin
				r.wrap_event = EV_TURN_INC;
				if (turn_count < TURN_HI)
					turn_count++;
				else
					r.turn_saturated = 1'b1;
			end else begin
				r.wrap_event = EV_SPURIOUS;
			end
		end
		last_angle = angle;

		offs = smp.counterclockwise ? reg_shadow.offset_ccw : reg_shadow.offset_cw;
		pos  = longint'(turn_count) * (longint'(1) << COUNT_BITS) + longint'(angle);
		if (smp.apply_abs_offset)
			pos -= longint'(signed'(reg_shadow.offset_abs));

		r.rotor_angle = angle - offs;
		r.position    = POSITION_BITS'(pos);
		r.turn_total  = TURN_BITS'(turn_count);
		return r;
	endfunction

	// Register settings for a random phase. The weight sometimes sits at zero, at one, or
	// above one; the step limit and wrap threshold mostly sit where a real axis uses them.
	function automatic cfg_t random_settings();
		cfg_t c;

		c.invert_count = 1'($urandom);
		case ($urandom_range(0, 5))
			0:       c.ema_weight = '0;
			1:       c.ema_weight = ALPHA_ONE;
			2:       c.ema_weight = ALPHA_BITS'($urandom_range(257, 511));
			default: c.ema_weight = ALPHA_BITS'($urandom_range(1, 255));
		endcase
		c.max_step       = ($urandom_range(0, 4) == 0) ? STEP_BITS'($urandom)
			: STEP_BITS'($urandom_range(256, 4096));
		c.cross_limit    = ($urandom_range(0, 4) == 0) ? STEP_BITS'($urandom)
			: STEP_BITS'($urandom_range(4096, 12000));
		c.offset_cw      = OFFSET_BITS'($urandom);
		c.offset_ccw     = OFFSET_BITS'($urandom);
		c.offset_abs     = ABS_OFFSET_BITS'($urandom);
		return c;
	endfunction

	// Next raw reading of the random walk. Most steps are ordinary motion that crosses
	// zero now and then; some land on or one count beside the step limit or the wrap
	// threshold, and a few are arbitrary jumps.
	function automatic logic [COUNT_BITS-1:0] next_reading(input logic [COUNT_BITS-1:0] from);
		int step;

		case ($urandom_range(0, 9))
			0: begin
				return COUNT_BITS'($urandom);
			end
			1: begin
				case ($urandom_range(0, 3))
					0:       step = int'(reg_shadow.max_step);
					1:       step = int'(reg_shadow.max_step) - 1;
					2:       step = int'(reg_shadow.cross_limit);
					default: step = int'(reg_shadow.cross_limit) + 1;
				endcase
				if ($urandom_range(0, 1) == 0)
					step = -step;
				return from + COUNT_BITS'(step);
			end
			default: begin
				step = int'($urandom_range(0, 1200)) - 600;
				return from + COUNT_BITS'(step);
			end
		endcase
	endfunction

	// Offers one sample beat and returns at the clock edge where it is taken. An optional
	// gap comes first; valid is only ever assigned once per edge.
	task automatic offer_sample(input item_t smp);
		int gap;

		gap = (gaps_on && $urandom_range(0, 3) == 0) ? pause_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		encoder_count    <= smp.encoder_count;
		counterclockwise <= smp.counterclockwise;
		apply_abs_offset <= smp.apply_abs_offset;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_sample(input item_t smp);
		offer_sample(smp);
		pending_results.push_back(track_sample(smp));
	endtask

	// Drops valid and waits until every owed result has come back and the drain margin has
	// passed, so that registers can be changed safely.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Writes the whole register file back to back. The unused upper data bits carry noise,
	// which the block must drop, and the spare index gets a write that must change nothing.
	task automatic apply_config(input cfg_t c);
		logic [CFG_DATA_BITS-1:0] noise;

		noise = CFG_DATA_BITS'($urandom);
		write_reg(REG_INVERT_COUNT, {noise[CFG_DATA_BITS-1:1], c.invert_count});
		write_reg(REG_EMA_WEIGHT, {noise[CFG_DATA_BITS-1:ALPHA_BITS], c.ema_weight});
		write_reg(REG_MAX_STEP, {noise[CFG_DATA_BITS-1:STEP_BITS], c.max_step});
		write_reg(REG_CROSS_LIMIT, {noise[CFG_DATA_BITS-1:STEP_BITS], c.cross_limit});
		write_reg(REG_OFFSET_CW, {noise[CFG_DATA_BITS-1:OFFSET_BITS], c.offset_cw});
		write_reg(REG_OFFSET_CCW, {noise[CFG_DATA_BITS-1:OFFSET_BITS], c.offset_ccw});
		write_reg(REG_OFFSET_ABS, c.offset_abs);
		write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
		cfg_we     <= 1'b0;
		reg_shadow  = c;
	endtask

	// Receiver. Each pass through the loop sets the stall once and holds it for a run of
	// cycles: either the one long hold-off on request, a random stall, or a random stretch
	// of free flow. With gaps switched off it only ever lets results through.
	initial begin : receiver
		forever begin
			if (hold_req) begin
				hold_req   = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (pause_len()) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Result checker. Every accepted result beat is matched against the oldest owed
	// result, field by field.
	always @(posedge clk) begin : result_check
		result_t want;

		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat arrived with no result owed");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rotor_angle_counts !== want.rotor_angle) begin
					$error("rotor_angle_counts: expected %0d, got %0d",
						want.rotor_angle, rotor_angle_counts);
					mismatch_count++;
				end
				if (absolute_position !== want.position) begin
					$error("absolute_position: expected %0d, got %0d",
						$signed(want.position), $signed(absolute_position));
					mismatch_count++;
				end
				if (turn_total !== want.turn_total) begin
					$error("turn_total: expected %0d, got %0d",
						$signed(want.turn_total), $signed(turn_total));
					mismatch_count++;
				end
				if (wrap_event !== want.wrap_event) begin
					$error("wrap_event: expected %0d, got %0d", want.wrap_event, wrap_event);
					mismatch_count++;
				end
				if (turn_saturated !== want.turn_saturated) begin
					$error("turn_saturated: expected %0d, got %0d",
						want.turn_saturated, turn_saturated);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: any accepted beat or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[multi_turn_encoder_tracker] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		item_t                 smp;
		cfg_t                  setting;
		logic [COUNT_BITS-1:0] raw;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		in_valid         <= 1'b0;
		encoder_count    <= '0;
		counterclockwise <= 1'b0;
		apply_abs_offset <= 1'b0;

		reg_shadow = RESET_SETTING;
		ema_acc    = '0;
		ema_seeded = 1'b0;
		last_angle = '0;
		turn_count = 0;
		raw        = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table with the reset register values.
		foreach (directed_rows[i]) begin
			smp = '{directed_rows[i].count, directed_rows[i].ccw, directed_rows[i].with_abs};
			if (directed_rows[i].typed) begin
				offer_sample(smp);
				void'(track_sample(smp));
				pending_results.push_back('{directed_rows[i].angle, directed_rows[i].position,
					directed_rows[i].turns, directed_rows[i].event_code, 1'b0});
			end else begin
				send_sample(smp);
			end
			raw = directed_rows[i].count;
		end

		// Random phases, each under its own register setting. The first two pin every
		// register at one end of its range; the rest are random. One phase asks for the
		// long receiver hold-off and one runs without any idling.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0:       setting = '{1'b1, '0, '0, '0, '1, '0, 30'h2000_0000};
				1:       setting = '{1'b0, '1, '1, '1, '0, '1, 30'h1FFF_FFFF};
				default: setting = random_settings();
			endcase
			apply_config(setting);
			gaps_on = (phase != 5);
			if (phase == 3)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				raw = next_reading(raw);
				smp = '{raw, 1'($urandom), 1'($urandom)};
				send_sample(smp);
			end
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("[multi_turn_encoder_tracker] OK");
		else
			$display("[multi_turn_encoder_tracker] ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/mtet_pkg.sv
sv/mtet_step.sv
sv/multi_turn_encoder_tracker.sv
tb/sv/multi_turn_encoder_tracker_tb.sv
